// ----- hdl/ordered_array_list_top_assert.svh -----
// Assertion macros shared by the ordered array list RTL.
`ifndef ORDERED_ARRAY_LIST_TOP_ASSERT_SVH
`define ORDERED_ARRAY_LIST_TOP_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define OAL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ordered_array_list: assertion failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define OAL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ordered_array_list: assertion failed");

`endif

// ----- hdl/oal_pkg.sv -----
// Shared types and constants for the ordered array list.
package oal_pkg;

    localparam int DATA_W  = 32;
    localparam int FUNC_W  = 3;
    localparam int POS_W   = 9;
    localparam int STAT_W  = 2;
    localparam int FIDX_W  = 8;
    localparam int LEN_W   = 9;
    localparam int SCAN_W  = 8;   // match flags examined per scan cycle
    localparam int SCAN_SH = 3;   // log2 of SCAN_W

    typedef enum logic [FUNC_W-1:0] {
        F_INSERT = 3'd0,
        F_DELETE = 3'd1,
        F_UPDATE = 3'd2,
        F_READ   = 3'd3,
        F_LOCATE = 3'd4,
        F_CLEAR  = 3'd5
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_BADPOS  = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic                     upd;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

    typedef struct packed {
        logic done;
        logic hit;
    } t_scan_stat;

endpackage

// ----- hdl/oal_cell.sv -----
// One list cell: holds an entry, shifts with its neighbors, flags a match.
module oal_cell #(
    parameter int CW   = 8,
    parameter int CNTW = 9,
    parameter int IDX  = 0
) (
    input  logic                              i_clk,
    input  oal_pkg::t_cell_ctl                i_ctl,
    input  logic [CW-1:0]                     i_k,
    input  logic [CNTW-1:0]                   i_count,
    input  logic signed [oal_pkg::DATA_W-1:0] i_left,
    input  logic signed [oal_pkg::DATA_W-1:0] i_right,
    output logic signed [oal_pkg::DATA_W-1:0] o_entry,
    output logic                              o_match
);

    logic signed [oal_pkg::DATA_W-1:0] r_entry;
    logic signed [oal_pkg::DATA_W-1:0] n_entry;
    logic                              w_at;
    logic                              w_above;

    assign w_at    = (i_k == CW'(IDX));
    assign w_above = (CW'(IDX) > i_k);

    always_comb begin
        n_entry = r_entry;
        priority if (i_ctl.ins) begin
            if (w_above) begin
                n_entry = i_left;
            end else if (w_at) begin
                n_entry = i_ctl.value;
            end
        end else if (i_ctl.del) begin
            if (w_at || w_above) begin
                n_entry = i_right;
            end
        end else if (i_ctl.upd) begin
            if (w_at) begin
                n_entry = i_ctl.value;
            end
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    // only live entries may match
    assign o_match = (CNTW'(IDX) < i_count) && (r_entry == i_ctl.value);

endmodule

// ----- hdl/oal_scan.sv -----
// First-match finder: walks the cell match flags one window per cycle.
module oal_scan #(
    parameter int CAPACITY = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic                                  i_run,
    input  logic [$clog2(CAPACITY+1)-1:0]         i_count,
    input  logic [CAPACITY-1:0]                   i_flags,
    output oal_pkg::t_scan_stat                   o_stat,
    output logic [$clog2(((CAPACITY+oal_pkg::SCAN_W-1)/oal_pkg::SCAN_W)
                         *oal_pkg::SCAN_W+1)-1:0] o_index
);

    localparam int NCHUNK = (CAPACITY + oal_pkg::SCAN_W - 1) / oal_pkg::SCAN_W;
    localparam int PADW   = NCHUNK * oal_pkg::SCAN_W;
    localparam int BW     = $clog2(PADW+1);
    localparam int CHW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    logic [CHW-1:0]                 r_chunk;
    logic [PADW-1:0]                w_flags_pad;
    logic [oal_pkg::SCAN_W-1:0]     w_win;
    logic [oal_pkg::SCAN_SH-1:0]    w_off;
    logic [BW-1:0]                  w_chunk_end;
    logic                           w_end;

    assign w_flags_pad = PADW'(i_flags);
    assign w_win       = w_flags_pad[r_chunk*oal_pkg::SCAN_W +: oal_pkg::SCAN_W];

    always_comb begin
        w_off = '0;
        for (int i = oal_pkg::SCAN_W-1; i >= 0; i--) begin
            if (w_win[i]) begin
                w_off = oal_pkg::SCAN_SH'(i);
            end
        end
    end

    assign w_chunk_end = (BW'(r_chunk) + BW'(1)) << oal_pkg::SCAN_SH;
    assign w_end       = (w_chunk_end >= BW'(i_count));

    assign o_stat.hit  = |w_win;
    assign o_stat.done = (|w_win) || w_end;
    assign o_index     = (BW'(r_chunk) << oal_pkg::SCAN_SH) | BW'(w_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= '0;
        end else if (i_start) begin
            r_chunk <= '0;
        end else if (i_run && !o_stat.done) begin
            r_chunk <= r_chunk + CHW'(1);
        end
    end

endmodule

// ----- hdl/ordered_array_list_top.sv -----
// Ordered array list top level: request decode, cell chain, scan and result register.
// Holds a dense list of up to CAPACITY signed 32-bit values in a row of cells.
// Insert, delete, update, read and clear finish in the cycle they are
// transferred: the cells shift or load in parallel and the result lands in
// the output register, so these requests go back to back at one per cycle
// while results are taken. Locate is transferred and then scans the match
// flags in windows of 8, at least one and at most ceil(length/8) of them,
// until the first hit; no request is taken during the scan.
// Entries need no clearing after reset. Unused operation codes return ok.
`include "ordered_array_list_top_assert.svh"

module ordered_array_list_top #(
    parameter int CAPACITY = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [oal_pkg::FUNC_W-1:0]        i_func,
    input  logic [oal_pkg::POS_W-1:0]         i_position,
    input  logic signed [oal_pkg::DATA_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [oal_pkg::STAT_W-1:0]        o_status,
    output logic signed [oal_pkg::DATA_W-1:0] o_read_value,
    output logic [oal_pkg::FIDX_W-1:0]        o_found_index,
    output logic [oal_pkg::LEN_W-1:0]         o_list_length
);

    localparam int CW     = $clog2(CAPACITY);
    localparam int CNTW   = $clog2(CAPACITY+1);
    localparam int CMPW   = (CNTW + 1 > oal_pkg::POS_W) ? CNTW + 1 : oal_pkg::POS_W;
    localparam int NCHUNK = (CAPACITY + oal_pkg::SCAN_W - 1) / oal_pkg::SCAN_W;
    localparam int BW     = $clog2(NCHUNK*oal_pkg::SCAN_W+1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state                            r_state;
    logic [CNTW-1:0]                   r_count;
    logic [CNTW-1:0]                   n_count;
    logic signed [oal_pkg::DATA_W-1:0] r_val;
    logic                              r_out_valid;
    oal_pkg::t_status                  r_status;
    logic signed [oal_pkg::DATA_W-1:0] r_rd;
    logic [oal_pkg::FIDX_W-1:0]        r_fidx;
    logic [oal_pkg::LEN_W-1:0]         r_len;

    logic signed [oal_pkg::DATA_W-1:0] w_entries [CAPACITY];
    logic signed [oal_pkg::DATA_W-1:0] w_left    [CAPACITY];
    logic signed [oal_pkg::DATA_W-1:0] w_right   [CAPACITY];
    logic [CAPACITY-1:0]               w_match;

    oal_pkg::t_cell_ctl                w_ctl;
    oal_pkg::t_scan_stat               w_scan;
    logic [BW-1:0]                     w_scan_idx;
    oal_pkg::t_status                  w_stat;
    logic signed [oal_pkg::DATA_W-1:0] w_rd;
    logic                              w_go_scan;
    logic                              w_accept;
    logic                              w_out_free;
    logic                              w_scan_fin;
    logic                              w_out_load;
    logic [CMPW-1:0]                   w_pos_x;
    logic [CMPW-1:0]                   w_cnt_x;
    logic                              w_pos_in;
    logic                              w_pos_ins;
    logic [oal_pkg::POS_W-1:0]         w_pos_m1;
    logic [CW-1:0]                     w_k;
    logic                              w_full;
    logic [oal_pkg::LEN_W+CNTW-1:0]    w_len_ext;
    logic [oal_pkg::FIDX_W+BW-1:0]     w_fidx_ext;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_pos_x   = CMPW'(i_position);
    assign w_cnt_x   = CMPW'(r_count);
    assign w_pos_in  = (i_position != '0) && (w_pos_x <= w_cnt_x);
    assign w_pos_ins = (i_position != '0) && (w_pos_x <= w_cnt_x + CMPW'(1));
    assign w_pos_m1  = i_position - oal_pkg::POS_W'(1);
    assign w_k       = CW'(w_pos_m1);
    assign w_full    = (r_count == CNTW'(CAPACITY));

    always_comb begin
        w_ctl.ins   = 1'b0;
        w_ctl.del   = 1'b0;
        w_ctl.upd   = 1'b0;
        w_ctl.value = (r_state == S_SCAN) ? r_val : i_value;
        n_count     = r_count;
        w_stat      = oal_pkg::ST_OK;
        w_rd        = '0;
        w_go_scan   = 1'b0;
        if (w_accept) begin
            unique case (oal_pkg::t_func'(i_func))
                oal_pkg::F_INSERT: begin
                    if (!w_pos_ins) begin
                        w_stat = oal_pkg::ST_BADPOS;
                    end else if (w_full) begin
                        w_stat = oal_pkg::ST_FULL;
                    end else begin
                        w_ctl.ins = 1'b1;
                        n_count   = r_count + CNTW'(1);
                    end
                end
                oal_pkg::F_DELETE: begin
                    if (!w_pos_in) begin
                        w_stat = oal_pkg::ST_BADPOS;
                    end else begin
                        w_rd      = w_entries[w_k];
                        w_ctl.del = 1'b1;
                        n_count   = r_count - CNTW'(1);
                    end
                end
                oal_pkg::F_UPDATE: begin
                    if (!w_pos_in) begin
                        w_stat = oal_pkg::ST_BADPOS;
                    end else begin
                        w_ctl.upd = 1'b1;
                    end
                end
                oal_pkg::F_READ: begin
                    if (!w_pos_in) begin
                        w_stat = oal_pkg::ST_BADPOS;
                    end else begin
                        w_rd = w_entries[w_k];
                    end
                end
                oal_pkg::F_LOCATE: begin
                    w_go_scan = 1'b1;
                end
                oal_pkg::F_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_left[g] = '0;
            end else begin : g_mid_l
                assign w_left[g] = w_entries[g-1];
            end
            if (g == CAPACITY-1) begin : g_last
                assign w_right[g] = '0;
            end else begin : g_mid_r
                assign w_right[g] = w_entries[g+1];
            end

            oal_cell #(
                .CW   (CW),
                .CNTW (CNTW),
                .IDX  (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_k     (w_k),
                .i_count (r_count),
                .i_left  (w_left[g]),
                .i_right (w_right[g]),
                .o_entry (w_entries[g]),
                .o_match (w_match[g])
            );
        end
    endgenerate

    oal_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && w_go_scan),
        .i_run   (r_state == S_SCAN),
        .i_count (r_count),
        .i_flags (w_match),
        .o_stat  (w_scan),
        .o_index (w_scan_idx)
    );

    assign w_scan_fin = (r_state == S_SCAN) && w_scan.done && w_out_free;
    assign w_out_load = (w_accept && !w_go_scan) || w_scan_fin;
    assign w_len_ext  = {oal_pkg::LEN_W'(0), n_count};
    assign w_fidx_ext = {oal_pkg::FIDX_W'(0), w_scan_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && w_go_scan) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_scan_fin) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_go_scan) begin
            r_val <= i_value;
        end
        if (w_scan_fin) begin
            r_status <= w_scan.hit ? oal_pkg::ST_OK : oal_pkg::ST_MISSING;
            r_rd     <= '0;
            r_fidx   <= w_scan.hit ? w_fidx_ext[oal_pkg::FIDX_W-1:0] : '0;
            r_len    <= w_len_ext[oal_pkg::LEN_W-1:0];
        end else if (w_out_load) begin
            r_status <= w_stat;
            r_rd     <= w_rd;
            r_fidx   <= '0;
            r_len    <= w_len_ext[oal_pkg::LEN_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_read_value  = r_rd;
    assign o_found_index = r_fidx;
    assign o_list_length = r_len;

    `OAL_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNTW'(CAPACITY))
    `OAL_ASSERT_NEXT(a_direct_result, w_accept && !w_go_scan, r_out_valid && r_state == S_IDLE)
    `OAL_ASSERT_IMP(a_scan_slot_free, r_state == S_SCAN, !r_out_valid)
    `OAL_ASSERT_NEXT(a_insert_grows, w_ctl.ins, r_count == $past(r_count) + CNTW'(1))

endmodule
